// ----- hw/rtl/ines_image_stream_parser_top_assert.svh -----
// assertion macros for the cartridge image parser rtl
// expects signals named clk and rst_n in the scope of each use
`ifndef INES_IMAGE_STREAM_PARSER_TOP_ASSERT_SVH
`define INES_IMAGE_STREAM_PARSER_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
// property checked on every edge outside reset
`define ISP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// antecedent this cycle implies consequent on the next edge
`define ISP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ISP_ASSERT(lbl, prop, msg)
`define ISP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ----- hw/rtl/ines_isp_pkg.sv -----
// types and constants for the cartridge image parser
// no dependencies; imported by every rtl module of the block
`timescale 1ns / 1ps

package ines_isp_pkg;

  localparam int unsigned OFF_W     = 22;
  localparam int unsigned HDR_LEN   = 16;
  localparam int unsigned TRN_LEN   = 512;
  localparam int unsigned PRG_SHIFT = 14;
  localparam int unsigned CHR_SHIFT = 13;

  localparam logic [OFF_W-1:0] OFF_MAX = '1;

  // header byte positions that are decoded
  localparam logic [3:0] HB_PRG   = 4'd4;
  localparam logic [3:0] HB_CHR   = 4'd5;
  localparam logic [3:0] HB_FLG6  = 4'd6;
  localparam logic [3:0] HB_FLG7  = 4'd7;
  localparam logic [3:0] HB_RAM   = 4'd8;
  localparam logic [3:0] HB_TV    = 4'd9;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_TRAINER = 3'd1,
    PH_PRG     = 3'd2,
    PH_CHR     = 3'd3,
    PH_TRAIL   = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SHORT_HDR = 3'd1,
    ST_PRG_TRUNC = 3'd2,
    ST_CHR_TRUNC = 3'd3,
    ST_PRG_RAM   = 3'd4
  } status_t;

  typedef struct packed {
    logic [7:0] image_byte;
    logic       image_end;
  } in_item_t;

  typedef struct packed {
    phase_t           region;
    logic [OFF_W-1:0] region_offset;
    logic [7:0]       byte_out;
    logic             parse_done;
    status_t          status;
    logic [7:0]       mapper_id;
    logic             mirror_vertical;
    logic             tv_pal;
    logic [4:0]       header_flags;
    logic [7:0]       prg_banks;
    logic [7:0]       chr_banks;
    logic [7:0]       prg_ram_banks;
  } result_t;

endpackage

// ----- hw/rtl/ines_isp_in_stage.sv -----
// input register of the cartridge image parser
// depends on ines_isp_pkg
`timescale 1ns / 1ps

module ines_isp_in_stage
  import ines_isp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_item,
  output logic     s1_valid,
  input  logic     s1_ready,
  output in_item_t s1_item
);

  logic     valid_r;
  logic     valid_nxt;
  in_item_t item_r;

  // take a new transfer whenever the register is empty or draining
  assign in_ready  = !valid_r || s1_ready;
  assign valid_nxt = in_valid ? 1'b1 : (valid_r && !s1_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= valid_nxt;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign s1_valid = valid_r;
  assign s1_item  = item_r;

endmodule

// ----- hw/rtl/ines_isp_parser.sv -----
// header decode, region tracking and status for the cartridge image parser
// depends on ines_isp_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "ines_image_stream_parser_top_assert.svh"

module ines_isp_parser
  import ines_isp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     s1_valid,
  output logic     s1_ready,
  input  in_item_t s1_item,
  output logic     res_valid,
  input  logic     res_ready,
  output result_t  res
);

  phase_t           phase_r, phase_nxt;
  logic [OFF_W-1:0] off_r, off_nxt;
  logic [7:0]       prg_r, prg_nxt;
  logic [7:0]       chr_r, chr_nxt;
  logic [7:0]       f6_r, f6_nxt;
  logic [7:0]       f7_r, f7_nxt;
  logic [7:0]       ram_r, ram_nxt;
  logic             pal_r, pal_nxt;

  logic             fire;
  logic [OFF_W-1:0] len;
  logic [OFF_W:0]   off_inc;
  logic             region_end;
  phase_t           after_prg, after_trn, after_hdr, follow;
  status_t          status;

  assign fire      = s1_valid && res_ready;
  assign s1_ready  = res_ready;
  assign res_valid = s1_valid;

  // header field capture
  always_comb begin
    prg_nxt = prg_r;
    chr_nxt = chr_r;
    f6_nxt  = f6_r;
    f7_nxt  = f7_r;
    ram_nxt = ram_r;
    pal_nxt = pal_r;
    if (phase_r == PH_HEADER) begin
      case (off_r[3:0])
        HB_PRG:  prg_nxt = s1_item.image_byte;
        HB_CHR:  chr_nxt = s1_item.image_byte;
        HB_FLG6: f6_nxt  = s1_item.image_byte;
        HB_FLG7: f7_nxt  = s1_item.image_byte;
        HB_RAM:  ram_nxt = s1_item.image_byte;
        HB_TV:   pal_nxt = s1_item.image_byte[0];
        default: ;
      endcase
    end
  end

  // length of the current region
  always_comb begin
    unique case (phase_r)
      PH_HEADER:  len = OFF_W'(HDR_LEN);
      PH_TRAINER: len = f6_nxt[2] ? OFF_W'(TRN_LEN) : '0;
      PH_PRG:     len = OFF_W'({prg_nxt, {PRG_SHIFT{1'b0}}});
      PH_CHR:     len = OFF_W'({chr_nxt, {CHR_SHIFT{1'b0}}});
      default:    len = '0;
    endcase
  end

  assign off_inc    = {1'b0, off_r} + {{OFF_W{1'b0}}, 1'b1};
  assign region_end = off_inc >= {1'b0, len};

  // next non-empty region, skipping those of zero length
  assign after_prg = (chr_nxt != 8'd0) ? PH_CHR : PH_TRAIL;
  assign after_trn = (prg_nxt != 8'd0) ? PH_PRG : after_prg;
  assign after_hdr = f6_nxt[2] ? PH_TRAINER : after_trn;

  always_comb begin
    unique case (phase_r)
      PH_HEADER:  follow = after_hdr;
      PH_TRAINER: follow = after_trn;
      PH_PRG:     follow = after_prg;
      default:    follow = PH_TRAIL;
    endcase
  end

  // phase and offset advance
  always_comb begin
    if (phase_r == PH_TRAIL) begin
      phase_nxt = PH_TRAIL;
      off_nxt   = (off_r == OFF_MAX) ? off_r : off_inc[OFF_W-1:0];
    end else if (region_end) begin
      phase_nxt = follow;
      off_nxt   = '0;
    end else begin
      phase_nxt = phase_r;
      off_nxt   = off_inc[OFF_W-1:0];
    end
  end

  // status on the final byte
  always_comb begin
    if (!s1_item.image_end) begin
      status = ST_OK;
    end else if (phase_r == PH_HEADER && phase_nxt == PH_HEADER) begin
      status = ST_SHORT_HDR;
    end else if (phase_nxt == PH_TRAINER || phase_nxt == PH_PRG) begin
      status = ST_PRG_TRUNC;
    end else if (phase_nxt == PH_CHR) begin
      status = ST_CHR_TRUNC;
    end else if (f6_nxt[1]) begin
      status = ST_PRG_RAM;
    end else begin
      status = ST_OK;
    end
  end

  // result item
  always_comb begin
    res.region          = phase_r;
    res.region_offset   = off_r;
    res.byte_out        = s1_item.image_byte;
    res.parse_done      = s1_item.image_end;
    res.status          = status;
    res.mapper_id       = {f7_nxt[7:4], f6_nxt[7:4]};
    res.mirror_vertical = f6_nxt[0];
    res.tv_pal          = pal_nxt;
    res.header_flags    = {f7_nxt[1:0], f6_nxt[3:1]};
    res.prg_banks       = prg_nxt;
    res.chr_banks       = chr_nxt;
    res.prg_ram_banks   = ram_nxt;
  end

  // parse state; the final byte returns everything to reset values
  always_ff @(posedge clk) begin
    if (!rst_n || (fire && s1_item.image_end)) begin
      phase_r <= PH_HEADER;
      off_r   <= '0;
      prg_r   <= '0;
      chr_r   <= '0;
      f6_r    <= '0;
      f7_r    <= '0;
      ram_r   <= '0;
      pal_r   <= 1'b0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      off_r   <= off_nxt;
      prg_r   <= prg_nxt;
      chr_r   <= chr_nxt;
      f6_r    <= f6_nxt;
      f7_r    <= f7_nxt;
      ram_r   <= ram_nxt;
      pal_r   <= pal_nxt;
    end
  end

  // header, trainer and program offsets stay inside their regions
  `ISP_ASSERT(a_hdr_off, (phase_r == PH_HEADER) |-> (off_r < OFF_W'(HDR_LEN)), "header offset")
  `ISP_ASSERT(a_trn_off, (phase_r == PH_TRAINER) |-> (f6_r[2] && off_r < OFF_W'(TRN_LEN)), "trainer offset")
  `ISP_ASSERT(a_prg_off, (phase_r == PH_PRG) |-> (off_r < OFF_W'({prg_r, {PRG_SHIFT{1'b0}}})), "program offset")
  `ISP_ASSERT_NEXT(a_restart, fire && s1_item.image_end, phase_r == PH_HEADER && off_r == '0, "no restart")
  `ISP_ASSERT_NEXT(a_trail, fire && !s1_item.image_end && phase_r == PH_TRAIL, phase_r == PH_TRAIL, "left trailer")

endmodule

// ----- hw/rtl/ines_isp_out_stage.sv -----
// result register of the cartridge image parser
// depends on ines_isp_pkg
`timescale 1ns / 1ps

module ines_isp_out_stage
  import ines_isp_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    res_valid,
  output logic    res_ready,
  input  result_t res,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);

  logic    valid_r;
  logic    valid_nxt;
  result_t res_r;

  // load when empty or when the held result is being taken
  assign res_ready = !valid_r || out_ready;
  assign valid_nxt = res_valid ? 1'b1 : (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (res_ready) begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

// ----- hw/rtl/ines_image_stream_parser_top.sv -----
// top level of the cartridge image stream parser
// depends on ines_isp_pkg, ines_isp_in_stage, ines_isp_parser, ines_isp_out_stage
`timescale 1ns / 1ps

// Feed the cartridge image one byte per transfer and mark the final byte with
// in_image_end. Every byte gives one result: its region (header, trainer,
// program rom, pattern rom, trailer), its offset in that region, the byte
// itself and the header fields decoded so far. The result of the final byte
// carries out_parse_done and the status, and the parser then starts over for
// a new image. One byte is taken every cycle while the result side does not
// stall; a result goes through the input register, then decode and offset
// compare into the result register; stalls on the result side hold both stages.
module ines_image_stream_parser_top
  import ines_isp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_image_byte,
  input  logic             in_image_end,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [2:0]       out_region,
  output logic [OFF_W-1:0] out_region_offset,
  output logic [7:0]       out_byte_out,
  output logic             out_parse_done,
  output logic [2:0]       out_status,
  output logic [7:0]       out_mapper_id,
  output logic             out_mirror_vertical,
  output logic             out_tv_pal,
  output logic [4:0]       out_header_flags,
  output logic [7:0]       out_prg_banks,
  output logic [7:0]       out_chr_banks,
  output logic [7:0]       out_prg_ram_banks
);

  in_item_t in_item, s1_item;
  logic     s1_valid, s1_ready;
  logic     res_valid, res_ready;
  result_t  res, out_res;

  assign in_item.image_byte = in_image_byte;
  assign in_item.image_end  = in_image_end;

  ines_isp_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .s1_valid (s1_valid),
    .s1_ready (s1_ready),
    .s1_item  (s1_item)
  );

  ines_isp_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_valid  (s1_valid),
    .s1_ready  (s1_ready),
    .s1_item   (s1_item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  ines_isp_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  // unpack the result register onto the ports
  assign out_region          = out_res.region;
  assign out_region_offset   = out_res.region_offset;
  assign out_byte_out        = out_res.byte_out;
  assign out_parse_done      = out_res.parse_done;
  assign out_status          = out_res.status;
  assign out_mapper_id       = out_res.mapper_id;
  assign out_mirror_vertical = out_res.mirror_vertical;
  assign out_tv_pal          = out_res.tv_pal;
  assign out_header_flags    = out_res.header_flags;
  assign out_prg_banks       = out_res.prg_banks;
  assign out_chr_banks       = out_res.chr_banks;
  assign out_prg_ram_banks   = out_res.prg_ram_banks;

endmodule
